// ===== hdl/i2cmbe_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// Shared types and constants for the I2C master bit engine: command codes,
// the tick item carried from the input register and the per-tick result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cmbe_pkg;

   // command codes
   localparam logic [2:0] MODE_START = 3'd0;
   localparam logic [2:0] MODE_STOP  = 3'd1;
   localparam logic [2:0] MODE_WRITE = 3'd2;
   localparam logic [2:0] MODE_READ  = 3'd3;
   localparam logic [2:0] MODE_SACK  = 3'd4;
   localparam logic [2:0] MODE_RACK  = 3'd5;

   // register reset and bit constants
   localparam logic [7:0] DEFAULT_HALF  = 8'd10;
   localparam logic [7:0] MSB_MASK      = 8'h80;
   localparam logic [2:0] LAST_BIT_IDX  = 3'd7;

   // one tick item as held in the input register
   typedef struct packed {
      logic       cmd_valid;
      logic [2:0] mode;
      logic [7:0] tx_byte;
      logic       ack_to_send;
      logic       sda_in;
   } tick_item_type;

   // per-tick result
   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_received;
   } tick_result_type;

endpackage

// ===== hdl/i2cmbe_req_stage.sv =====
// ----------------------------------------------------------------------------
// i2cmbe_req_stage
// Input register for tick items. Holds one item and raises stall while that
// item cannot move on into the engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cmbe_req_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  i2cmbe_pkg::tick_item_type req_item,
   input  logic                    sink_free,
   output logic                    item_valid,
   output logic                    item_fire,
   output i2cmbe_pkg::tick_item_type item
);
   import i2cmbe_pkg::*;

   logic          valid_ff;
   logic          valid_in;
   tick_item_type item_ff;
   logic          accept;

   // the held item moves on whenever the result side has room
   assign item_fire  = valid_ff & sink_free;
   assign req_stall  = valid_ff & ~sink_free;
   assign accept     = req_valid & ~req_stall;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   // occupancy of the input register
   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (item_fire) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload capture
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

endmodule

// ===== hdl/i2cmbe_engine.sv =====
// ----------------------------------------------------------------------------
// i2cmbe_engine
// Bit engine state and its one-tick update: start, stop, byte write, byte
// read, ack send and ack receive pin sequences with a half-period delay.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cmbe_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  i2cmbe_pkg::tick_item_type   item,
   input  logic [7:0]                  half_period,
   output i2cmbe_pkg::tick_result_type result,
   output logic                        busy_state,
   output logic [2:0]                  phase_state,
   output logic [7:0]                  delay_state
);
   import i2cmbe_pkg::*;

   // sequence phases
   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_ONE  = 3'd1;
   localparam logic [2:0] PH_TWO  = 3'd2;
   localparam logic [2:0] PH_THREE = 3'd3;

   logic [2:0] mode_ff,  mode_in;
   logic [2:0] phase_ff, phase_in;
   logic [2:0] bit_ff,   bit_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] delay_ff, delay_in;
   logic       scl_ff,   scl_in;
   logic       sda_ff,   sda_in;
   logic       ack_ff,   ack_in;
   logic [7:0] rx_ff,    rx_in;
   logic       busy_ff,  busy_in;
   logic       done;
   logic [7:0] half_eff;
   logic [2:0] bit_next;
   logic [7:0] shift_sampled;

   // a zero half period counts as one tick
   assign half_eff = (half_period == 8'd0) ? 8'd1 : half_period;
   assign bit_next = bit_ff + 3'd1;
   assign shift_sampled = shift_ff | ((MSB_MASK >> bit_ff) & {8{item.sda_in}});

   // next state for one tick
   always_comb begin
      mode_in  = mode_ff;
      phase_in = phase_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      delay_in = delay_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      ack_in   = ack_ff;
      rx_in    = rx_ff;
      busy_in  = busy_ff;
      done     = 1'b0;
      if (busy_ff) begin
         if (delay_ff > 8'd1) begin
            delay_in = delay_ff - 8'd1;
         end else begin
            // delay expired: take the next action of the sequence
            busy_in  = 1'b0;
            phase_in = PH_IDLE;
            delay_in = 8'd0;
            done     = 1'b1;
            unique case (mode_ff)
               MODE_START: begin
                  if (phase_ff == PH_ONE) begin
                     sda_in = 1'b0;
                     phase_in = PH_TWO;
                  end else if (phase_ff == PH_TWO) begin
                     scl_in = 1'b0;
                     phase_in = PH_THREE;
                  end
               end
               MODE_STOP: begin
                  if (phase_ff == PH_ONE) begin
                     scl_in = 1'b1;
                     phase_in = PH_TWO;
                  end else if (phase_ff == PH_TWO) begin
                     sda_in = 1'b1;
                     phase_in = PH_THREE;
                  end
               end
               MODE_WRITE, MODE_SACK: begin
                  if (phase_ff == PH_ONE) begin
                     scl_in = 1'b1;
                     phase_in = PH_TWO;
                  end else if (phase_ff == PH_TWO) begin
                     scl_in = 1'b0;
                     phase_in = PH_THREE;
                  end else if (mode_ff == MODE_SACK) begin
                     if (phase_ff == PH_THREE) begin
                        sda_in = 1'b1;
                     end
                  end else if (phase_ff == PH_THREE && bit_ff != LAST_BIT_IDX) begin
                     bit_in = bit_next;
                     sda_in = |(shift_ff & (MSB_MASK >> bit_next));
                     phase_in = PH_ONE;
                  end
               end
               MODE_READ: begin
                  if (phase_ff == PH_ONE) begin
                     scl_in = 1'b1;
                     phase_in = PH_TWO;
                  end else if (phase_ff == PH_TWO) begin
                     shift_in = shift_sampled;
                     scl_in   = 1'b0;
                     if (bit_ff == LAST_BIT_IDX) begin
                        rx_in = shift_sampled;
                     end else begin
                        bit_in = bit_next;
                        phase_in = PH_ONE;
                     end
                  end
               end
               MODE_RACK: begin
                  if (phase_ff == PH_ONE) begin
                     scl_in = 1'b1;
                     phase_in = PH_TWO;
                  end else if (phase_ff == PH_TWO) begin
                     ack_in = item.sda_in;
                     scl_in = 1'b0;
                     phase_in = PH_THREE;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
            // any new phase means a fresh delay step, not the end
            if (phase_in != PH_IDLE) begin
               busy_in  = 1'b1;
               delay_in = half_eff;
               done     = 1'b0;
            end
         end
      end else if (item.cmd_valid && item.mode <= MODE_RACK) begin
         // accept a command and drive its first pin levels
         mode_in  = item.mode;
         bit_in   = 3'd0;
         busy_in  = 1'b1;
         phase_in = PH_ONE;
         delay_in = half_eff;
         unique case (item.mode)
            MODE_START: begin
               sda_in = 1'b1;
               scl_in = 1'b1;
            end
            MODE_STOP: begin
               sda_in = 1'b0;
            end
            MODE_WRITE: begin
               shift_in = item.tx_byte;
               sda_in   = item.tx_byte[7];
            end
            MODE_READ: begin
               shift_in = 8'd0;
               sda_in   = 1'b1;
            end
            MODE_SACK: begin
               sda_in = item.ack_to_send;
            end
            default: begin
               sda_in = 1'b1;
            end
         endcase
      end
   end

   // the result carries the state after this tick
   always_comb begin
      result.scl_level    = scl_in;
      result.sda_level    = sda_in;
      result.busy_res     = busy_in;
      result.done_res     = done;
      result.rx_byte      = rx_in;
      result.ack_received = ack_in;
   end

   assign busy_state  = busy_ff;
   assign phase_state = phase_ff;
   assign delay_state = delay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 3'd0;
         phase_ff <= PH_IDLE;
         bit_ff   <= 3'd0;
         shift_ff <= 8'd0;
         delay_ff <= 8'd0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         ack_ff   <= 1'b0;
         rx_ff    <= 8'd0;
         busy_ff  <= 1'b0;
      end else if (step) begin
         mode_ff  <= mode_in;
         phase_ff <= phase_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         delay_ff <= delay_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
         ack_ff   <= ack_in;
         rx_ff    <= rx_in;
         busy_ff  <= busy_in;
      end
   end

endmodule

// ===== hdl/i2c_master_bit_engine_core.sv =====
// A tick item's result is loaded into the result register as the item leaves the input register.
// One tick item per cycle while the result register is not stalled; the engine state steps once per item.
// The input register stalls only while the result register is full and stalled.
// Synchronous active-high reset: idle engine, SCL and SDA released high,
// half period back to 10 ticks, both registers empty.
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_core
// I2C master bit engine: input register, tick engine, result register and
// the half-period configuration register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_master_bit_engine_core (
   input  logic       clock,
   input  logic       reset,
   // tick items in
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_cmd_valid,
   input  logic [2:0] req_mode,
   input  logic [7:0] req_tx_byte,
   input  logic       req_ack_to_send,
   input  logic       req_sda_in,
   // results out
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_scl_level,
   output logic       rsp_sda_level,
   output logic       rsp_busy_res,
   output logic       rsp_done_res,
   output logic [7:0] rsp_rx_byte,
   output logic       rsp_ack_received,
   // configuration
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_half_period_ticks
);
   import i2cmbe_pkg::*;

   tick_item_type   req_item;
   tick_item_type   item;
   tick_result_type result;
   tick_result_type rsp_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      half_ff;
   logic            sink_free;
   logic            item_valid;
   logic            item_fire;
   logic            busy_state;
   logic [2:0]      phase_state;
   logic [7:0]      delay_state;

   assign req_item.cmd_valid   = req_cmd_valid;
   assign req_item.mode        = req_mode;
   assign req_item.tx_byte     = req_tx_byte;
   assign req_item.ack_to_send = req_ack_to_send;
   assign req_item.sda_in      = req_sda_in;

   // result register has room when empty or being drained
   assign sink_free = ~rsp_valid_ff | ~rsp_stall;

   i2cmbe_req_stage u_req_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .sink_free  (sink_free),
      .item_valid (item_valid),
      .item_fire  (item_fire),
      .item       (item)
   );

   i2cmbe_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .step        (item_fire),
      .item        (item),
      .half_period (half_ff),
      .result      (result),
      .busy_state  (busy_state),
      .phase_state (phase_state),
      .delay_state (delay_state)
   );

   // configuration register, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= DEFAULT_HALF;
      end else if (csr_valid && csr_ready) begin
         half_ff <= csr_half_period_ticks;
      end
   end

   // result register occupancy
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (item_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_scl_level    = rsp_ff.scl_level;
   assign rsp_sda_level    = rsp_ff.sda_level;
   assign rsp_busy_res     = rsp_ff.busy_res;
   assign rsp_done_res     = rsp_ff.done_res;
   assign rsp_rx_byte      = rsp_ff.rx_byte;
   assign rsp_ack_received = rsp_ff.ack_received;

   // a busy engine always has a delay step running
   a_busy_delay: assert property (@(posedge clock) disable iff (reset)
      busy_state |-> (delay_state != 8'd0))
      else $error("busy engine with no delay step");

   // idle engine sits in the idle phase, busy engine never does
   a_idle_phase: assert property (@(posedge clock) disable iff (reset)
      busy_state == (phase_state != 3'd0))
      else $error("phase and busy flag disagree");

   // a finishing tick never reports busy
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_res) |-> !rsp_busy_res)
      else $error("done reported together with busy");

   // the engine only steps on a held item
   a_fire_held: assert property (@(posedge clock) disable iff (reset)
      item_fire |-> item_valid)
      else $error("engine stepped without an item");

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the I2C master bit engine. Every accepted tick item
// is run through a local model of the engine, and each tick result coming
// out is compared field by field with the oldest pending prediction. Covers
// all six commands, ignored commands, zero, one tick and long half periods,
// random command streams under several idling patterns and a long result stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   import i2cmbe_pkg::*;

   // mode codes the engine has no command for
   localparam logic [2:0] MODE_SPARE_LO = 3'd6;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;

   // engine phases
   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_FIRST  = 3'd1;
   localparam logic [2:0] PH_SECOND = 3'd2;
   localparam logic [2:0] PH_THIRD  = 3'd3;

   // sda_in patterns for directed commands
   localparam int SDA_LOW    = 0;
   localparam int SDA_HIGH   = 1;
   localparam int SDA_RANDOM = 2;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int SETTLE_CYCLES  = 4;
   localparam int TAIL_CYCLES    = 8;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_cmd_valid = 1'b0;
   logic [2:0] req_mode = '0;
   logic [7:0] req_tx_byte = '0;
   logic       req_ack_to_send = 1'b0;
   logic       req_sda_in = 1'b1;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_scl_level;
   logic       rsp_sda_level;
   logic       rsp_busy_res;
   logic       rsp_done_res;
   logic [7:0] rsp_rx_byte;
   logic       rsp_ack_received;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_half_period_ticks = DEFAULT_HALF;

   // idling controls, written by the test tasks
   int send_idle_pct = 0;
   int stall_pct = 0;
   int holdoff_req = 0;

   int error_count = 0;
   int ticks_sent = 0;
   int ticks_checked = 0;
   int commands_done = 0;
   int settings_used = 0;

   tick_result_type pin_results_due[$];

   // local copy of the engine state and its register
   logic [7:0] half_q  = DEFAULT_HALF;
   logic [2:0] mode_q  = MODE_START;
   logic [2:0] phase_q = PH_IDLE;
   logic [2:0] bit_q   = '0;
   logic [7:0] shift_q = '0;
   logic [7:0] delay_q = '0;
   logic       scl_q   = 1'b1;
   logic       sda_q   = 1'b1;
   logic       ack_q   = 1'b0;
   logic [7:0] rx_q    = '0;
   logic       busy_q  = 1'b0;
   logic       done_q  = 1'b0;

   i2c_master_bit_engine_core DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_cmd_valid         (req_cmd_valid),
      .req_mode              (req_mode),
      .req_tx_byte           (req_tx_byte),
      .req_ack_to_send       (req_ack_to_send),
      .req_sda_in            (req_sda_in),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_scl_level         (rsp_scl_level),
      .rsp_sda_level         (rsp_sda_level),
      .rsp_busy_res          (rsp_busy_res),
      .rsp_done_res          (rsp_done_res),
      .rsp_rx_byte           (rsp_rx_byte),
      .rsp_ack_received      (rsp_ack_received),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_half_period_ticks (csr_half_period_ticks)
   );

   // clock, 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // engine model
   // ------------------------------------------------------------------

   // load the delay step, zero half period counts as one tick
   function automatic void arm_delay(input logic [2:0] next_phase);
      delay_q = (half_q != 8'd0) ? half_q : 8'd1;
      phase_q = next_phase;
   endfunction

   function automatic void finish_command();
      phase_q = PH_IDLE;
      busy_q  = 1'b0;
      delay_q = '0;
      done_q  = 1'b1;
   endfunction

   function automatic logic shift_out_bit();
      return shift_q[3'd7 - bit_q];
   endfunction

   // pin action when a delay step runs out
   function automatic void advance_phase(input logic sda);
      case (mode_q)
         MODE_START: begin
            if (phase_q == PH_FIRST) begin
               sda_q = 1'b0;
               arm_delay(PH_SECOND);
            end else if (phase_q == PH_SECOND) begin
               scl_q = 1'b0;
               arm_delay(PH_THIRD);
            end else finish_command();
         end
         MODE_STOP: begin
            if (phase_q == PH_FIRST) begin
               scl_q = 1'b1;
               arm_delay(PH_SECOND);
            end else if (phase_q == PH_SECOND) begin
               sda_q = 1'b1;
               arm_delay(PH_THIRD);
            end else finish_command();
         end
         MODE_WRITE, MODE_SACK: begin
            if (phase_q == PH_FIRST) begin
               scl_q = 1'b1;
               arm_delay(PH_SECOND);
            end else if (phase_q == PH_SECOND) begin
               scl_q = 1'b0;
               arm_delay(PH_THIRD);
            end else if (mode_q == MODE_SACK) begin
               // release sda as the ack bit ends
               if (phase_q == PH_THIRD) sda_q = 1'b1;
               finish_command();
            end else if (phase_q == PH_THIRD && bit_q < LAST_BIT_IDX) begin
               bit_q = bit_q + 3'd1;
               sda_q = shift_out_bit();
               arm_delay(PH_FIRST);
            end else finish_command();
         end
         MODE_READ: begin
            if (phase_q == PH_FIRST) begin
               scl_q = 1'b1;
               arm_delay(PH_SECOND);
            end else if (phase_q == PH_SECOND) begin
               // sample while scl is high, then drop scl
               if (sda) shift_q[3'd7 - bit_q] = 1'b1;
               scl_q = 1'b0;
               if (bit_q >= LAST_BIT_IDX) begin
                  rx_q = shift_q;
                  finish_command();
               end else begin
                  bit_q = bit_q + 3'd1;
                  arm_delay(PH_FIRST);
               end
            end else finish_command();
         end
         MODE_RACK: begin
            if (phase_q == PH_FIRST) begin
               scl_q = 1'b1;
               arm_delay(PH_SECOND);
            end else if (phase_q == PH_SECOND) begin
               ack_q = sda;
               scl_q = 1'b0;
               arm_delay(PH_THIRD);
            end else finish_command();
         end
         default: finish_command();
      endcase
   endfunction

   // step the engine model by one tick item
   function automatic void engine_step(input tick_item_type it, output tick_result_type res);
      done_q = 1'b0;
      if (busy_q) begin
         if (delay_q > 8'd1) begin
            delay_q = delay_q - 8'd1;
         end else begin
            delay_q = '0;
            advance_phase(it.sda_in);
         end
      end else if (it.cmd_valid && it.mode <= MODE_RACK) begin
         mode_q = it.mode;
         bit_q  = '0;
         busy_q = 1'b1;
         case (it.mode)
            MODE_START: begin
               sda_q = 1'b1;
               scl_q = 1'b1;
            end
            MODE_STOP: sda_q = 1'b0;
            MODE_WRITE: begin
               shift_q = it.tx_byte;
               sda_q = shift_out_bit();
            end
            MODE_READ: begin
               shift_q = '0;
               sda_q = 1'b1;
            end
            MODE_SACK: sda_q = it.ack_to_send;
            default: sda_q = 1'b1;
         endcase
         arm_delay(PH_FIRST);
      end
      if (done_q) commands_done++;
      res.scl_level    = scl_q;
      res.sda_level    = sda_q;
      res.busy_res     = busy_q;
      res.done_res     = done_q;
      res.rx_byte      = rx_q;
      res.ack_received = ack_q;
   endfunction

   // ------------------------------------------------------------------
   // result checking
   // ------------------------------------------------------------------

   task automatic report_field(input string name, input logic [7:0] got, input logic [7:0] want);
      $display("mismatch on %s at result %0d: got %0h, want %0h", name, ticks_checked, got, want);
      error_count++;
   endtask

   task automatic check_pins();
      tick_result_type want;
      if (pin_results_due.size() == 0) begin
         $display("result %0d arrived with no tick item pending", ticks_checked);
         error_count++;
      end else begin
         want = pin_results_due.pop_front();
         if (rsp_scl_level !== want.scl_level)
            report_field("scl_level", 8'(rsp_scl_level), 8'(want.scl_level));
         if (rsp_sda_level !== want.sda_level)
            report_field("sda_level", 8'(rsp_sda_level), 8'(want.sda_level));
         if (rsp_busy_res !== want.busy_res)
            report_field("busy_res", 8'(rsp_busy_res), 8'(want.busy_res));
         if (rsp_done_res !== want.done_res)
            report_field("done_res", 8'(rsp_done_res), 8'(want.done_res));
         if (rsp_rx_byte !== want.rx_byte)
            report_field("rx_byte", rsp_rx_byte, want.rx_byte);
         if (rsp_ack_received !== want.ack_received)
            report_field("ack_received", 8'(rsp_ack_received), 8'(want.ack_received));
      end
      ticks_checked++;
   endtask

   // receiver: check accepted results, then choose the next stall
   int holdoff_seen = 0;
   int hold_left = 0;
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_pins();
      if (holdoff_req != holdoff_seen) begin
         holdoff_seen = holdoff_req;
         hold_left = HOLDOFF_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // watchdog on cycles with no handshake at all
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   // offer one tick item, with a random gap first, and predict its result
   task automatic send_tick(input tick_item_type it);
      tick_result_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd_valid   <= it.cmd_valid;
      req_mode        <= it.mode;
      req_tx_byte     <= it.tx_byte;
      req_ack_to_send <= it.ack_to_send;
      req_sda_in      <= it.sda_in;
      do @(posedge clock); while (req_stall);
      engine_step(it, res);
      pin_results_due.push_back(res);
      ticks_sent++;
   endtask

   // drop valid straight after the last accepted item
   task automatic idle_sender();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic pick_sda(input int sel);
      if (sel == SDA_LOW) return 1'b0;
      if (sel == SDA_HIGH) return 1'b1;
      return 1'($urandom_range(1));
   endfunction

   // a tick with random fields; commands offered only as noise
   function automatic tick_item_type noise_tick(input int sda_sel);
      tick_item_type it;
      it.cmd_valid   = 1'($urandom_range(1));
      it.mode        = 3'($urandom_range(7));
      it.tx_byte     = 8'($urandom_range(255));
      it.ack_to_send = 1'($urandom_range(1));
      it.sda_in      = pick_sda(sda_sel);
      return it;
   endfunction

   // issue one command and tick until the engine is idle again
   task automatic run_command(input logic [2:0] mode, input logic [7:0] tx, input logic ack,
                              input int sda_sel);
      tick_item_type it;
      it = noise_tick(sda_sel);
      it.cmd_valid = 1'b1;
      it.mode = mode;
      it.tx_byte = tx;
      it.ack_to_send = ack;
      send_tick(it);
      while (busy_q) send_tick(noise_tick(sda_sel));
   endtask

   // finish any command, then wait for every pending result
   task automatic settle_engine();
      while (busy_q) send_tick(noise_tick(SDA_RANDOM));
      idle_sender();
      while (pin_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_half_period(input logic [7:0] value);
      settle_engine();
      csr_half_period_ticks <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      half_q = value;
      settings_used++;
      @(posedge clock);
   endtask

   // random ticks: mostly real commands when idle, noise while busy
   task automatic random_ticks(input int count);
      tick_item_type it;
      int pick;
      repeat (count) begin
         it = noise_tick(SDA_RANDOM);
         if (!busy_q) begin
            it.cmd_valid = ($urandom_range(9) < 8);
            pick = $urandom_range(19);
            if (pick < 18) it.mode = 3'(pick % 6);
            else it.mode = (pick == 18) ? MODE_SPARE_LO : MODE_SPARE_HI;
         end
         send_tick(it);
      end
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // reset outputs, then start, ack receive and stop at the reset half period
   task automatic test_default_period();
      tick_item_type it;
      send_idle_pct = 0;
      stall_pct = 0;
      it = noise_tick(SDA_HIGH);
      it.cmd_valid = 1'b0;
      send_tick(it);
      run_command(MODE_START, 8'h00, 1'b0, SDA_RANDOM);
      run_command(MODE_RACK, 8'h00, 1'b0, SDA_HIGH);
      run_command(MODE_STOP, 8'h00, 1'b0, SDA_RANDOM);
      settle_engine();
   endtask

   // zero half period, byte extremes, ack values and spare modes
   task automatic test_short_period();
      set_half_period(8'd0);
      run_command(MODE_START, 8'h00, 1'b0, SDA_RANDOM);
      run_command(MODE_WRITE, 8'h00, 1'b0, SDA_RANDOM);
      run_command(MODE_WRITE, 8'hA5, 1'b0, SDA_RANDOM);
      run_command(MODE_RACK, 8'h00, 1'b0, SDA_LOW);
      run_command(MODE_READ, 8'h00, 1'b0, SDA_HIGH);
      run_command(MODE_READ, 8'h00, 1'b0, SDA_LOW);
      run_command(MODE_SACK, 8'h00, 1'b0, SDA_RANDOM);
      run_command(MODE_SPARE_LO, 8'hFF, 1'b1, SDA_RANDOM);
      run_command(MODE_SPARE_HI, 8'h00, 1'b0, SDA_RANDOM);
      set_half_period(8'd1);
      run_command(MODE_READ, 8'h00, 1'b0, SDA_RANDOM);
      run_command(MODE_STOP, 8'h00, 1'b0, SDA_RANDOM);
   endtask

   // a long half period on one start, under light idling
   task automatic test_long_period();
      set_half_period(8'd50);
      send_idle_pct = 31;
      stall_pct = 31;
      run_command(MODE_START, 8'h00, 1'b0, SDA_RANDOM);
      settle_engine();
   endtask

   // random command streams under each idling pattern
   task automatic test_random_streams();
      set_half_period(8'd1);
      send_idle_pct = 0;
      stall_pct = 0;
      random_ticks(35);
      set_half_period(8'd2);
      send_idle_pct = 78;
      stall_pct = 0;
      random_ticks(35);
      set_half_period(8'd3);
      send_idle_pct = 0;
      stall_pct = 78;
      random_ticks(35);
      set_half_period(8'($urandom_range(6, 1)));
      send_idle_pct = 31;
      stall_pct = 31;
      random_ticks(35);
   endtask

   // long receiver hold-off while ticks keep coming, then a full pause
   task automatic test_fill_and_stall();
      set_half_period(8'd2);
      send_idle_pct = 0;
      stall_pct = 0;
      holdoff_req <= holdoff_req + 1;
      random_ticks(30);
      settle_engine();
      random_ticks(10);
      settle_engine();
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_period();
      test_short_period();
      test_long_period();
      test_random_streams();
      test_fill_and_stall();
      idle_sender();
      while (pin_results_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pin_results_due.size() != 0) begin
         $display("%0d tick results never arrived", pin_results_due.size());
         error_count++;
      end
      $display("ran %0d ticks, %0d commands finished, %0d half-period settings",
               ticks_sent, commands_done, settings_used);
      $display("idling: none, sender, receiver, both, plus a long result hold-off");
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/i2cmbe_pkg.sv
hdl/i2cmbe_req_stage.sv
hdl/i2cmbe_engine.sv
hdl/i2c_master_bit_engine_core.sv
dv/testbench.sv
